@@ design/cvkf_pkg.sv @@
// shared types, constants, saturation helpers and the per-axis microprogram
package cvkf_pkg;

    localparam int AXES_MAX = 3;
    localparam int WORK_W   = 52;
    localparam int MAG_W    = 47;
    localparam int COV_FRAC = 24;
    localparam int PC_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [PC_W-1:0] UOP_LAST = PC_W'(33);

    localparam logic [MAG_W-1:0] LIM_MAG = {MAG_W{1'b1}};
    localparam logic signed [WORK_W-1:0] LIM_W = {{(WORK_W-MAG_W){1'b0}}, LIM_MAG};
    localparam logic signed [WORK_W-1:0] MAX32 = WORK_W'(64'sd2147483647);
    localparam logic signed [WORK_W-1:0] MIN32 = -WORK_W'(64'sd2147483648);

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VARIANCE  = 2'd2;

    typedef struct packed {
        logic signed [31:0] meas_pos_x;
        logic signed [31:0] meas_pos_y;
        logic signed [31:0] meas_pos_z;
        logic signed [31:0] meas_vel_x;
        logic signed [31:0] meas_vel_y;
        logic signed [31:0] meas_vel_z;
        logic [17:0]        step_time;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] est_pos_x;
        logic signed [31:0] est_pos_y;
        logic signed [31:0] est_pos_z;
        logic signed [31:0] est_vel_x;
        logic signed [31:0] est_vel_y;
        logic signed [31:0] est_vel_z;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE, S_AXIS, S_ISSUE, S_WAIT, S_STORE, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        OP_PASS, OP_MUL_DT, OP_MUL_COV, OP_DIV, OP_CHECK
    } t_op;

    typedef enum logic [1:0] {
        SAT_NONE, SAT_48, SAT_32
    } t_sat;

    typedef enum logic [4:0] {
        R_ZERO, R_XP, R_XV, R_P00, R_P01, R_P11, R_ZP, R_ZV, R_DT, R_Q, R_R,
        R_T, R_TMP, R_TMP2, R_DETP, R_DET, R_N0, R_N1, R_K00, R_K01, R_K11,
        R_E0, R_E1
    } t_reg;

    // dst = sat(c +/- op(a, b))
    typedef struct packed {
        t_op  op;
        t_reg a;
        t_reg b;
        t_reg c;
        logic sub;
        t_sat sat;
        t_reg dst;
    } t_uop;

    typedef struct packed {
        logic start;
        logic frac_shift;
    } t_mul_ctl;

    function automatic t_uop mk(input t_op op, input t_reg a, input t_reg b, input t_reg c,
                                input logic sub, input t_sat sat, input t_reg dst);
        t_uop u;
        u.op = op; u.a = a; u.b = b; u.c = c; u.sub = sub; u.sat = sat; u.dst = dst;
        return u;
    endfunction

    function automatic t_uop uop_at(input logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            // predict
            6'd0:  u = mk(OP_MUL_DT,  R_XV,   R_DT,  R_XP,   1'b0, SAT_32,   R_XP);
            6'd1:  u = mk(OP_MUL_DT,  R_P11,  R_DT,  R_P01,  1'b0, SAT_48,   R_T);
            6'd2:  u = mk(OP_MUL_DT,  R_P01,  R_DT,  R_P00,  1'b0, SAT_NONE, R_TMP);
            6'd3:  u = mk(OP_MUL_DT,  R_T,    R_DT,  R_TMP,  1'b0, SAT_NONE, R_TMP);
            6'd4:  u = mk(OP_PASS,    R_Q,    R_ZERO, R_TMP, 1'b0, SAT_48,   R_P00);
            6'd5:  u = mk(OP_PASS,    R_T,    R_ZERO, R_ZERO, 1'b0, SAT_NONE, R_P01);
            6'd6:  u = mk(OP_PASS,    R_Q,    R_ZERO, R_P11, 1'b0, SAT_48,   R_P11);
            // innovation determinant and gain numerators
            6'd7:  u = mk(OP_MUL_COV, R_P00,  R_P11, R_ZERO, 1'b0, SAT_NONE, R_TMP);
            6'd8:  u = mk(OP_MUL_COV, R_P01,  R_P01, R_TMP,  1'b1, SAT_48,   R_DETP);
            6'd9:  u = mk(OP_MUL_COV, R_R,    R_P00, R_DETP, 1'b0, SAT_NONE, R_TMP);
            6'd10: u = mk(OP_PASS,    R_TMP,  R_ZERO, R_ZERO, 1'b0, SAT_48,  R_N0);
            6'd11: u = mk(OP_MUL_COV, R_R,    R_P11, R_ZERO, 1'b0, SAT_NONE, R_TMP2);
            6'd12: u = mk(OP_PASS,    R_TMP2, R_ZERO, R_DETP, 1'b0, SAT_48,  R_N1);
            6'd13: u = mk(OP_PASS,    R_TMP2, R_ZERO, R_TMP, 1'b0, SAT_NONE, R_TMP);
            6'd14: u = mk(OP_MUL_COV, R_R,    R_R,   R_TMP,  1'b0, SAT_48,   R_DET);
            6'd15: u = mk(OP_CHECK,   R_ZERO, R_ZERO, R_ZERO, 1'b0, SAT_NONE, R_ZERO);
            // gains
            6'd16: u = mk(OP_DIV,     R_N0,   R_DET, R_ZERO, 1'b0, SAT_NONE, R_K00);
            6'd17: u = mk(OP_MUL_COV, R_R,    R_P01, R_ZERO, 1'b0, SAT_NONE, R_TMP);
            6'd18: u = mk(OP_DIV,     R_TMP,  R_DET, R_ZERO, 1'b0, SAT_NONE, R_K01);
            6'd19: u = mk(OP_DIV,     R_N1,   R_DET, R_ZERO, 1'b0, SAT_NONE, R_K11);
            // state correction
            6'd20: u = mk(OP_PASS,    R_XP,   R_ZERO, R_ZP,  1'b1, SAT_NONE, R_E0);
            6'd21: u = mk(OP_PASS,    R_XV,   R_ZERO, R_ZV,  1'b1, SAT_NONE, R_E1);
            6'd22: u = mk(OP_MUL_COV, R_K00,  R_E0,  R_XP,   1'b0, SAT_NONE, R_TMP);
            6'd23: u = mk(OP_MUL_COV, R_K01,  R_E1,  R_TMP,  1'b0, SAT_32,   R_XP);
            6'd24: u = mk(OP_MUL_COV, R_K01,  R_E0,  R_XV,   1'b0, SAT_NONE, R_TMP);
            6'd25: u = mk(OP_MUL_COV, R_K11,  R_E1,  R_TMP,  1'b0, SAT_32,   R_XV);
            // covariance correction on the predicted covariance
            6'd26: u = mk(OP_MUL_COV, R_K00,  R_P00, R_P00,  1'b1, SAT_NONE, R_TMP);
            6'd27: u = mk(OP_MUL_COV, R_K01,  R_P01, R_TMP,  1'b1, SAT_48,   R_N0);
            6'd28: u = mk(OP_MUL_COV, R_K00,  R_P01, R_P01,  1'b1, SAT_NONE, R_TMP);
            6'd29: u = mk(OP_MUL_COV, R_K01,  R_P11, R_TMP,  1'b1, SAT_48,   R_N1);
            6'd30: u = mk(OP_MUL_COV, R_K01,  R_P01, R_P11,  1'b1, SAT_NONE, R_TMP);
            6'd31: u = mk(OP_MUL_COV, R_K11,  R_P11, R_TMP,  1'b1, SAT_48,   R_P11);
            6'd32: u = mk(OP_PASS,    R_N0,   R_ZERO, R_ZERO, 1'b0, SAT_NONE, R_P00);
            6'd33: u = mk(OP_PASS,    R_N1,   R_ZERO, R_ZERO, 1'b0, SAT_NONE, R_P01);
            default: u = mk(OP_CHECK, R_ZERO, R_ZERO, R_ZERO, 1'b0, SAT_NONE, R_ZERO);
        endcase
        return u;
    endfunction

    function automatic logic [MAG_W-1:0] mag47(input logic signed [WORK_W-1:0] x);
        logic [WORK_W-1:0] a;
        a = x[WORK_W-1] ? WORK_W'(-x) : WORK_W'(x);
        return (a > WORK_W'(LIM_MAG)) ? LIM_MAG : a[MAG_W-1:0];
    endfunction

    function automatic logic signed [WORK_W-1:0] sat48(input logic signed [WORK_W-1:0] x);
        if (x > LIM_W) begin
            return LIM_W;
        end else if (x < -LIM_W) begin
            return -LIM_W;
        end
        return x;
    endfunction

    function automatic logic signed [WORK_W-1:0] sat32(input logic signed [WORK_W-1:0] x);
        if (x > MAX32) begin
            return MAX32;
        end else if (x < MIN32) begin
            return MIN32;
        end
        return x;
    endfunction

endpackage

@@ design/cvkf_mul.sv @@
// shared multiplier: rounded, saturated fixed-point product over four 24x24 partial products
module cvkf_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cvkf_pkg::t_mul_ctl                  i_ctl,
    input  logic [4:0]                          i_frac,
    input  logic signed [cvkf_pkg::WORK_W-1:0]  i_a,
    input  logic signed [cvkf_pkg::WORK_W-1:0]  i_b,
    output logic                                o_done,
    output logic signed [cvkf_pkg::WORK_W-1:0]  o_result
);
    import cvkf_pkg::*;

    localparam int PROD_W = 2 * MAG_W;

    logic [MAG_W-1:0]  r_ua, r_ub;
    logic              r_neg;
    logic [4:0]        r_shift;
    logic [PROD_W-1:0] r_acc;
    logic [2:0]        r_step;
    logic              r_busy;
    logic              r_done;
    logic signed [WORK_W-1:0] r_result;

    logic [23:0]       pa, pb;
    logic [47:0]       pp;
    logic [PROD_W-1:0] pp_sh;
    logic [PROD_W:0]   rnd, shd;
    logic [MAG_W-1:0]  res_mag;
    logic [WORK_W-1:0] res_ext;

    always_comb begin
        pa = r_step[0] ? {1'b0, r_ua[MAG_W-1:24]} : r_ua[23:0];
        pb = r_step[1] ? {1'b0, r_ub[MAG_W-1:24]} : r_ub[23:0];
        pp = pa * pb;
        pp_sh = PROD_W'(pp);
        if (r_step[0]) begin
            pp_sh = pp_sh << 24;
        end
        if (r_step[1]) begin
            pp_sh = pp_sh << 24;
        end
        // round half away from zero on the magnitude
        rnd = {1'b0, r_acc} + ((PROD_W+1)'(1) << (r_shift - 5'd1));
        shd = rnd >> r_shift;
        res_mag = (|shd[PROD_W:MAG_W]) ? LIM_MAG : shd[MAG_W-1:0];
        res_ext = {{(WORK_W-MAG_W){1'b0}}, res_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_ua    <= mag47(i_a);
                r_ub    <= mag47(i_b);
                r_neg   <= i_a[WORK_W-1] ^ i_b[WORK_W-1];
                r_shift <= i_ctl.frac_shift ? i_frac : 5'(COV_FRAC);
                r_acc   <= '0;
                r_step  <= '0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (r_step != 3'd4) begin
                    r_acc  <= r_acc + pp_sh;
                    r_step <= r_step + 3'd1;
                end else begin
                    r_result <= r_neg ? -signed'(res_ext) : signed'(res_ext);
                    r_done   <= 1'b1;
                    r_busy   <= 1'b0;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ design/cvkf_div.sv @@
// shared divider: round(n * 2^24 / d) by restoring division, one quotient bit per cycle
module cvkf_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [cvkf_pkg::WORK_W-1:0]  i_n,
    input  logic signed [cvkf_pkg::WORK_W-1:0]  i_d,
    output logic                                o_done,
    output logic signed [cvkf_pkg::WORK_W-1:0]  o_result
);
    import cvkf_pkg::*;

    localparam int DVD_W = MAG_W + 1 + COV_FRAC;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_sh;
    logic [MAG_W-1:0] r_rem;
    logic [MAG_W-1:0] r_d;
    logic [MAG_W:0]   r_q;
    logic             r_over;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic signed [WORK_W-1:0] r_result;

    logic [MAG_W:0]   rem_s;
    logic             ge;
    logic [MAG_W:0]   rem_n;
    logic [MAG_W:0]   q_sh, q_n;
    logic             up;
    logic [MAG_W+1:0] q_f;
    logic [MAG_W-1:0] q_mag;
    logic [WORK_W-1:0] q_ext;

    always_comb begin
        rem_s = {r_rem, r_sh[DVD_W-1]};
        ge    = rem_s >= {1'b0, r_d};
        rem_n = ge ? rem_s - {1'b0, r_d} : rem_s;
        q_sh  = r_over ? r_q : {r_q[MAG_W-1:0], 1'b0};
        q_n   = (ge && !r_over) ? (q_sh | (MAG_W+1)'(1)) : q_sh;
        up    = !r_over && ({r_rem, 1'b0} >= {1'b0, r_d});
        q_f   = {1'b0, r_q} + (MAG_W+2)'(up);
        q_mag = (r_over || q_f > (MAG_W+2)'(LIM_MAG)) ? LIM_MAG : q_f[MAG_W-1:0];
        q_ext = {{(WORK_W-MAG_W){1'b0}}, q_mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_sh   <= {1'b0, mag47(i_n), {COV_FRAC{1'b0}}};
                r_rem  <= '0;
                r_d    <= i_d[MAG_W-1:0];
                r_q    <= '0;
                r_over <= 1'b0;
                r_neg  <= i_n[WORK_W-1];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt != CNT_W'(DVD_W)) begin
                    r_sh   <= {r_sh[DVD_W-2:0], 1'b0};
                    r_rem  <= rem_n[MAG_W-1:0];
                    r_q    <= q_n;
                    r_over <= r_over | q_n[MAG_W];
                    r_cnt  <= r_cnt + CNT_W'(1);
                end else begin
                    r_result <= r_neg ? -signed'(q_ext) : signed'(q_ext);
                    r_done   <= 1'b1;
                    r_busy   <= 1'b0;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ design/constant_velocity_kalman_filter_core.sv @@
// three-axis constant-velocity tracking filter: sequencer, working registers, axis state
// a first item (after reset or restart) takes each axis measurement as its estimate;
// a filtered item runs the microprogram for each axis in turn, its time set by the restoring
// divide (72 quotient steps) for each of three gains per axis and by twenty products on the
// one shared multiplier
// throughput: one item at a time; the next request is taken once the result is registered
// reset: synchronous active low; loads default noise values and initial covariance
module constant_velocity_kalman_filter_core #(
    parameter int NUM_AXES  = 3,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  cvkf_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output cvkf_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [cvkf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [31:0]                            i_cfg_data
);
    import cvkf_pkg::*;

    localparam int W = WORK_W;
    localparam logic [1:0] AXIS_LAST = 2'(NUM_AXES - 1);

    t_state r_state, n_state;
    logic [31:0] r_process_noise, r_measurement_noise, r_initial_variance;
    t_in_item    r_in;
    logic        r_started;
    logic [1:0]  r_axis;
    logic [PC_W-1:0] r_pc;
    logic        r_out_valid;
    t_out_item   r_out;

    logic signed [31:0] r_pos [AXES_MAX];
    logic signed [31:0] r_vel [AXES_MAX];
    logic signed [47:0] r_cpp [AXES_MAX];
    logic signed [47:0] r_cpv [AXES_MAX];
    logic signed [47:0] r_cvv [AXES_MAX];

    logic signed [W-1:0] r_xp, r_xv, r_p00, r_p01, r_p11, r_t, r_tmp, r_tmp2;
    logic signed [W-1:0] r_detp, r_det, r_n0, r_n1, r_k00, r_k01, r_k11, r_e0, r_e1;

    logic signed [W-1:0] zp, zv, dt, qn, rn, init_cov;
    logic signed [W-1:0] opa, opb, opc, res, sum, wval;
    t_uop     uop;
    t_mul_ctl mul_ctl;
    logic     div_start, mul_done, div_done, unit_done;
    logic signed [W-1:0] mul_res, div_res;
    logic     do_write, pc_adv, out_load, det_bad, last;

    function automatic logic signed [W-1:0] to_cov(input logic [31:0] v);
        logic [55:0] w;
        w = 56'(v) << (COV_FRAC - FRAC_BITS);
        return (w > 56'(LIM_MAG)) ? LIM_W : W'(w);
    endfunction

    function automatic logic signed [W-1:0] sx32(input logic signed [31:0] v);
        return {{(W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [W-1:0] sx48(input logic signed [47:0] v);
        return {{(W-48){v[47]}}, v};
    endfunction

    function automatic logic signed [W-1:0] rd(input t_reg s);
        case (s)
            R_XP:    return r_xp;
            R_XV:    return r_xv;
            R_P00:   return r_p00;
            R_P01:   return r_p01;
            R_P11:   return r_p11;
            R_ZP:    return zp;
            R_ZV:    return zv;
            R_DT:    return dt;
            R_Q:     return qn;
            R_R:     return rn;
            R_T:     return r_t;
            R_TMP:   return r_tmp;
            R_TMP2:  return r_tmp2;
            R_DETP:  return r_detp;
            R_DET:   return r_det;
            R_N0:    return r_n0;
            R_N1:    return r_n1;
            R_K00:   return r_k00;
            R_K01:   return r_k01;
            R_K11:   return r_k11;
            R_E0:    return r_e0;
            R_E1:    return r_e1;
            default: return '0;
        endcase
    endfunction

    always_comb begin
        case (r_axis)
            2'd0: begin
                zp = sx32(r_in.meas_pos_x);
                zv = sx32(r_in.meas_vel_x);
            end
            2'd1: begin
                zp = sx32(r_in.meas_pos_y);
                zv = sx32(r_in.meas_vel_y);
            end
            default: begin
                zp = sx32(r_in.meas_pos_z);
                zv = sx32(r_in.meas_vel_z);
            end
        endcase
        dt       = {{(W-18){1'b0}}, r_in.step_time};
        qn       = to_cov(r_process_noise);
        rn       = to_cov(r_measurement_noise);
        init_cov = to_cov(r_initial_variance);
        uop      = uop_at(r_pc);
        last     = r_pc == UOP_LAST;
        det_bad  = r_det[W-1] || (r_det == '0);
        opa      = rd(uop.a);
        opb      = rd(uop.b);
        opc      = rd(uop.c);
        case (uop.op)
            OP_MUL_DT, OP_MUL_COV: res = mul_res;
            OP_DIV:                res = div_res;
            default:               res = opa;
        endcase
        sum = uop.sub ? opc - res : opc + res;
        case (uop.sat)
            SAT_48:  wval = sat48(sum);
            SAT_32:  wval = sat32(sum);
            default: wval = sum;
        endcase
    end

    assign unit_done = mul_done | div_done;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_AXIS;
                end
            end
            S_AXIS: begin
                n_state = r_started ? S_ISSUE : S_STORE;
            end
            S_ISSUE: begin
                case (uop.op)
                    OP_PASS:  n_state = last ? S_STORE : S_ISSUE;
                    OP_CHECK: n_state = (det_bad || last) ? S_STORE : S_ISSUE;
                    default:  n_state = S_WAIT;
                endcase
            end
            S_WAIT: begin
                if (unit_done) begin
                    n_state = last ? S_STORE : S_ISSUE;
                end
            end
            S_STORE: begin
                n_state = (r_axis == AXIS_LAST) ? S_FINISH : S_AXIS;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_ready         = 1'b0;
        mul_ctl.start      = 1'b0;
        mul_ctl.frac_shift = uop.op == OP_MUL_DT;
        div_start          = 1'b0;
        do_write           = 1'b0;
        pc_adv             = 1'b0;
        out_load           = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_ISSUE: begin
                mul_ctl.start = (uop.op == OP_MUL_DT) || (uop.op == OP_MUL_COV);
                div_start     = uop.op == OP_DIV;
                do_write      = uop.op == OP_PASS;
                pc_adv        = (uop.op == OP_PASS) || (uop.op == OP_CHECK);
            end
            S_WAIT: begin
                do_write = unit_done;
                pc_adv   = unit_done;
            end
            S_FINISH: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration, axis state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise     <= 32'd655;
            r_measurement_noise <= 32'd6554;
            r_initial_variance  <= 32'd6553600;
            r_started           <= 1'b0;
            r_out_valid         <= 1'b0;
            r_axis              <= '0;
            r_pc                <= '0;
            for (int a = 0; a < AXES_MAX; a++) begin
                r_pos[a] <= '0;
                r_vel[a] <= '0;
                r_cpp[a] <= 48'(to_cov(32'd6553600));
                r_cpv[a] <= '0;
                r_cvv[a] <= 48'(to_cov(32'd6553600));
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE:     r_process_noise     <= i_cfg_data;
                    CFG_MEASUREMENT_NOISE: r_measurement_noise <= i_cfg_data;
                    CFG_INITIAL_VARIANCE:  r_initial_variance  <= i_cfg_data;
                    default:               r_process_noise     <= r_process_noise;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_in_ready && i_in_valid) begin
                r_axis <= '0;
                if (i_in_data.restart) begin
                    r_started <= 1'b0;
                    for (int a = 0; a < AXES_MAX; a++) begin
                        r_pos[a] <= '0;
                        r_vel[a] <= '0;
                        r_cpp[a] <= 48'(init_cov);
                        r_cpv[a] <= '0;
                        r_cvv[a] <= 48'(init_cov);
                    end
                end
            end
            if (r_state == S_AXIS) begin
                r_pc <= '0;
            end else if (pc_adv) begin
                r_pc <= r_pc + PC_W'(1);
            end
            if (r_state == S_STORE) begin
                r_pos[r_axis] <= r_xp[31:0];
                r_vel[r_axis] <= r_xv[31:0];
                r_cpp[r_axis] <= r_p00[47:0];
                r_cpv[r_axis] <= r_p01[47:0];
                r_cvv[r_axis] <= r_p11[47:0];
                r_axis        <= r_axis + 2'd1;
            end
            if (out_load) begin
                r_started   <= 1'b1;
                r_out_valid <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (out_load) begin
            r_out.est_pos_x <= (NUM_AXES > 0) ? r_pos[0] : '0;
            r_out.est_vel_x <= (NUM_AXES > 0) ? r_vel[0] : '0;
            r_out.est_pos_y <= (NUM_AXES > 1) ? r_pos[1] : '0;
            r_out.est_vel_y <= (NUM_AXES > 1) ? r_vel[1] : '0;
            r_out.est_pos_z <= (NUM_AXES > 2) ? r_pos[2] : '0;
            r_out.est_vel_z <= (NUM_AXES > 2) ? r_vel[2] : '0;
        end
        if (r_state == S_AXIS) begin
            r_p00 <= sx48(r_cpp[r_axis]);
            r_p01 <= sx48(r_cpv[r_axis]);
            r_p11 <= sx48(r_cvv[r_axis]);
            // first item takes the measurement as the estimate
            r_xp  <= r_started ? sx32(r_pos[r_axis]) : zp;
            r_xv  <= r_started ? sx32(r_vel[r_axis]) : zv;
        end else if (do_write) begin
            case (uop.dst)
                R_XP:    r_xp   <= wval;
                R_XV:    r_xv   <= wval;
                R_P00:   r_p00  <= wval;
                R_P01:   r_p01  <= wval;
                R_P11:   r_p11  <= wval;
                R_T:     r_t    <= wval;
                R_TMP:   r_tmp  <= wval;
                R_TMP2:  r_tmp2 <= wval;
                R_DETP:  r_detp <= wval;
                R_DET:   r_det  <= wval;
                R_N0:    r_n0   <= wval;
                R_N1:    r_n1   <= wval;
                R_K00:   r_k00  <= wval;
                R_K01:   r_k01  <= wval;
                R_K11:   r_k11  <= wval;
                R_E0:    r_e0   <= wval;
                R_E1:    r_e1   <= wval;
                default: r_tmp  <= r_tmp;
            endcase
        end
    end

    cvkf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mul_ctl),
        .i_frac   (5'(FRAC_BITS)),
        .i_a      (opa),
        .i_b      (opb),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    cvkf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_n      (opa),
        .i_d      (opb),
        .o_done   (div_done),
        .o_result (div_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/cvkf_chk.sv @@
// port-level checker for the tracking filter core, with its bind
module cvkf_chk #(
    parameter int NUM_AXES = 3
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input cvkf_pkg::t_out_item            o_out_data
);
    import cvkf_pkg::*;

    // a held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a request occupies the block for at least the cycle after it
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken back to back");

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the z axis reads zero when fewer than three axes are configured
    a_unused_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (NUM_AXES < 3) |->
            o_out_data.est_pos_z == '0 && o_out_data.est_vel_z == '0)
        else $error("unused axis not zero");

endmodule

bind constant_velocity_kalman_filter_core cvkf_chk #(.NUM_AXES(NUM_AXES)) u_cvkf_chk (.*);
